// ===== rtl/core/hobt_pkg.sv =====
// Shared types and constants for the hashed order book table.
package hobt_pkg;
   localparam logic [31:0] FNV_BASIS = 32'd2166136261;
   localparam logic [31:0] HASH_MULT = 32'd16777619;

   localparam logic [2:0] KIND_NEW     = 3'd0;
   localparam logic [2:0] KIND_UPDATED = 3'd1;
   localparam logic [2:0] KIND_INVALID = 3'd2;
   localparam logic [2:0] KIND_FULL    = 3'd3;
   localparam logic [2:0] KIND_NO_SELL = 3'd4;
   localparam logic [2:0] KIND_NO_BUY  = 3'd5;
   localparam logic [2:0] KIND_MATCH   = 3'd6;

   localparam int unsigned TICKER_W = 64;
   localparam int unsigned PRICE_W  = 31;
   localparam int unsigned SLOT_W   = 6;

   typedef logic [2:0] kind_type;
endpackage

// ===== rtl/core/hashed_order_book_table.sv =====
// Hashed order book table: FNV-1a hashed, linear probed order store with matching pass.
// Add: hashes up to TICKER_BYTES ticker bytes, stopping at a zero byte, then probes linearly
//   from the hashed slot, at most TABLE_DEPTH probes. Match: scans all slots for the lowest sell,
//   then scans again to emit buys at or above it; one item at a time, and output stalls delay any item.
// Reset clears control state and the per-slot valid flags; memory contents need no clearing.
// The next item is taken once the last result of the current item is loaded for output.
module hashed_order_book_table #(
   parameter int TABLE_DEPTH  = 64,
   parameter int TICKER_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic        req_side,
   input  logic [63:0] req_ticker,
   input  logic signed [31:0] req_quantity,
   input  logic signed [31:0] req_price,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_result_kind,
   output logic [5:0]  rsp_slot,
   output logic [30:0] rsp_lowest_sell_price,
   output logic [63:0] rsp_match_ticker,
   output logic [30:0] rsp_match_price,
   output logic        rsp_last
);
   import hobt_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = AW + 1;
   localparam int BW = (TICKER_BYTES > 1) ? $clog2(TICKER_BYTES + 1) : 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_HASH  = 3'd1;
   localparam logic [2:0] S_PROBE = 3'd2;
   localparam logic [2:0] S_LOW   = 3'd3;
   localparam logic [2:0] S_EMIT  = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   // Table memory: ticker, side, price, quantity; valid flags in flip-flops.
   logic [63:0]  mem_ticker [TABLE_DEPTH];
   logic         mem_side   [TABLE_DEPTH];
   logic [30:0]  mem_price  [TABLE_DEPTH];
   logic [30:0]  mem_qty    [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ff;

   logic [2:0]   state_ff, state_in;
   logic         side_ff;
   logic [63:0]  raw_tick_ff; // raw ticker held from the request
   logic [63:0]  tick_ff;     // canonical ticker, built during hashing
   logic [31:0]  hash_ff;
   logic [BW-1:0] byte_ff;
   logic         stop_ff;     // zero byte seen
   logic [30:0]  qty_ff, prc_ff;
   logic [AW-1:0] idx_ff;     // current probe/scan address
   logic [CW-1:0] cnt_ff;     // steps issued
   logic         rd_ok_ff;    // a read is in flight for rd_idx_ff
   logic [AW-1:0] rd_idx_ff;
   logic         rd_vld_ff;
   logic [63:0]  rd_tick_ff;
   logic         rd_side_ff;
   logic [30:0]  rd_price_ff;
   logic [30:0]  rd_qty_ff;
   logic         have_ff;
   logic [30:0]  low_ff;
   logic         any_ff;      // a matching buy already seen
   logic         pend_ff;     // held match result awaiting the next one
   logic [AW-1:0] pslot_ff;
   logic [63:0]  ptick_ff;
   logic [30:0]  pprice_ff;
   kind_type     stat_ff;     // kind of the pending single status result

   logic         out_v_ff;
   logic [2:0]   out_k_ff;
   logic [5:0]   out_s_ff;
   logic [30:0]  out_l_ff, out_p_ff;
   logic [63:0]  out_t_ff;
   logic         out_last_ff;

   logic         req_take, out_free;
   assign out_free  = !out_v_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;

   function automatic logic [7:0] req_ticker_ff_byte(input logic [63:0] t,
                                                    input logic [BW-1:0] b);
      req_ticker_ff_byte = t[8*b +: 8];
   endfunction

   logic [7:0]  cur_byte;
   logic [31:0] hx;
   logic [31:0] hmul;
   assign cur_byte = req_ticker_ff_byte(raw_tick_ff, byte_ff);

   // only the low 32 bits of the product matter
   assign hx   = hash_ff ^ {24'd0, cur_byte};
   assign hmul = hx * HASH_MULT;

   logic rd_hit;
   assign rd_hit = rd_vld_ff && (rd_tick_ff == tick_ff);

   // Hold the read data while its result waits for the output register.
   logic rd_hold;
   assign rd_hold = !out_free && ((state_ff == S_EMIT) ||
                    (state_ff == S_PROBE && rd_ok_ff && (!rd_vld_ff || rd_hit)));

   always_ff @(posedge clock) begin
      if (!rd_hold) begin
         rd_vld_ff   <= valid_ff[idx_ff];
         rd_tick_ff  <= mem_ticker[idx_ff];
         rd_side_ff  <= mem_side[idx_ff];
         rd_price_ff <= mem_price[idx_ff];
         rd_qty_ff   <= mem_qty[idx_ff];
         rd_idx_ff   <= idx_ff;
      end
      if (state_ff == S_PROBE && rd_ok_ff && (!rd_vld_ff || rd_hit) && out_free) begin
         mem_ticker[rd_idx_ff] <= tick_ff;
         mem_side[rd_idx_ff]   <= side_ff;
         mem_price[rd_idx_ff]  <= prc_ff;
         mem_qty[rd_idx_ff]    <= qty_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
   end

   always_ff @(posedge clock) begin
      logic out_load;
      out_load = 1'b0;
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         out_v_ff <= 1'b0;
         rd_ok_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (req_take) begin
               side_ff     <= req_side;
               raw_tick_ff <= req_ticker;
               qty_ff      <= req_quantity[30:0];
               prc_ff      <= req_price[30:0];
               hash_ff     <= FNV_BASIS;
               tick_ff     <= '0;
               byte_ff     <= '0;
               stop_ff     <= 1'b0;
               idx_ff      <= '0;
               cnt_ff      <= '0;
               rd_ok_ff    <= 1'b0;
               have_ff     <= 1'b0;
               any_ff      <= 1'b0;
               pend_ff     <= 1'b0;
               if (req_mode) state_ff <= S_LOW;
               else if (req_quantity <= 0 || req_price <= 0) begin
                  stat_ff  <= KIND_INVALID;
                  state_ff <= S_OUT;
               end else state_ff <= S_HASH;
            end
            S_HASH: begin
               // one byte per cycle; stop at zero byte or TICKER_BYTES
               if (!stop_ff && cur_byte != 8'd0) begin
                  hash_ff <= hmul;
                  tick_ff[8*byte_ff +: 8] <= cur_byte;
               end else stop_ff <= 1'b1;
               if (byte_ff == BW'(TICKER_BYTES - 1) || stop_ff || cur_byte == 8'd0) begin
                  state_ff <= S_PROBE;
                  if (!stop_ff && cur_byte != 8'd0)
                     idx_ff <= AW'(hmul & 32'(TABLE_DEPTH - 1));
                  else
                     idx_ff <= AW'(hash_ff & 32'(TABLE_DEPTH - 1));
               end else byte_ff <= byte_ff + 1'b1;
            end
            S_PROBE: begin
               if (rd_ok_ff && (!rd_vld_ff || rd_hit)) begin
                  if (out_free) begin
                     valid_ff[rd_idx_ff] <= 1'b1;
                     out_load     = 1'b1;
                     out_k_ff    <= rd_vld_ff ? KIND_UPDATED : KIND_NEW;
                     out_s_ff    <= 6'(rd_idx_ff);
                     out_l_ff    <= '0; out_t_ff <= '0; out_p_ff <= '0;
                     out_last_ff <= 1'b1;
                     rd_ok_ff    <= 1'b0;
                     state_ff    <= S_IDLE;
                  end
               end else if (cnt_ff == CW'(TABLE_DEPTH)) begin
                  stat_ff  <= KIND_FULL;
                  rd_ok_ff <= 1'b0;
                  state_ff <= S_OUT;
               end else begin
                  // issue next probe; wrap at the table end
                  rd_ok_ff <= 1'b1;
                  idx_ff   <= (idx_ff == AW'(TABLE_DEPTH - 1)) ? '0 : idx_ff + 1'b1;
                  cnt_ff   <= cnt_ff + 1'b1;
               end
            end
            S_LOW: begin
               // scan for lowest sell; read data is registered behind the address
               if (rd_ok_ff && rd_vld_ff && rd_side_ff &&
                   (!have_ff || rd_price_ff < low_ff)) begin
                  have_ff <= 1'b1;
                  low_ff  <= rd_price_ff;
               end
               if (cnt_ff == CW'(TABLE_DEPTH)) begin
                  rd_ok_ff <= 1'b0;
                  cnt_ff   <= '0;
                  idx_ff   <= '0;
                  if (!(have_ff || (rd_ok_ff && rd_vld_ff && rd_side_ff))) begin
                     stat_ff  <= KIND_NO_SELL;
                     state_ff <= S_OUT;
                  end else state_ff <= S_EMIT;
               end else begin
                  rd_ok_ff <= 1'b1;
                  idx_ff   <= (idx_ff == AW'(TABLE_DEPTH - 1)) ? '0 : idx_ff + 1'b1;
                  cnt_ff   <= cnt_ff + 1'b1;
               end
            end
            S_EMIT: if (out_free) begin
               // hold one match so the final one can carry last
               if (rd_ok_ff && rd_vld_ff && !rd_side_ff && rd_price_ff >= low_ff) begin
                  if (pend_ff) begin
                     out_load  = 1'b1; out_k_ff <= KIND_MATCH;
                     out_s_ff <= 6'(pslot_ff); out_l_ff <= low_ff;
                     out_t_ff <= ptick_ff; out_p_ff <= pprice_ff; out_last_ff <= 1'b0;
                  end
                  pend_ff <= 1'b1; any_ff <= 1'b1;
                  pslot_ff <= rd_idx_ff; ptick_ff <= rd_tick_ff; pprice_ff <= rd_price_ff;
               end
               if (cnt_ff == CW'(TABLE_DEPTH)) begin
                  rd_ok_ff <= 1'b0;
                  if (!(rd_ok_ff && rd_vld_ff && !rd_side_ff && rd_price_ff >= low_ff)) begin
                     state_ff <= S_IDLE;
                     out_load  = 1'b1; out_last_ff <= 1'b1; out_l_ff <= low_ff;
                     if (pend_ff) begin
                        out_k_ff <= KIND_MATCH; out_s_ff <= 6'(pslot_ff);
                        out_t_ff <= ptick_ff; out_p_ff <= pprice_ff;
                     end else begin
                        out_k_ff <= KIND_NO_BUY; out_s_ff <= '0;
                        out_t_ff <= '0; out_p_ff <= '0;
                     end
                     pend_ff <= 1'b0;
                  end else cnt_ff <= CW'(TABLE_DEPTH) + 1'b1;
               end else if (cnt_ff == CW'(TABLE_DEPTH) + 1'b1) begin
                  // last buy was just captured: flush it
                  state_ff <= S_IDLE; pend_ff <= 1'b0;
               end else begin
                  rd_ok_ff <= 1'b1;
                  idx_ff   <= (idx_ff == AW'(TABLE_DEPTH - 1)) ? '0 : idx_ff + 1'b1;
                  cnt_ff   <= cnt_ff + 1'b1;
               end
               if (cnt_ff == CW'(TABLE_DEPTH) + 1'b1) begin
                  out_load  = 1'b1; out_k_ff <= KIND_MATCH; out_last_ff <= 1'b1;
                  out_s_ff <= 6'(pslot_ff); out_l_ff <= low_ff;
                  out_t_ff <= ptick_ff; out_p_ff <= pprice_ff;
               end
            end
            S_OUT: if (out_free) begin
               // single status result
               out_load  = 1'b1;
               out_k_ff <= stat_ff;
               out_s_ff <= '0; out_t_ff <= '0; out_p_ff <= '0;
               out_l_ff <= '0;
               out_last_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
         // hold a stalled result, drop a taken one, load a new one
         out_v_ff <= out_load || (out_v_ff && rsp_stall);
      end
   end

   assign rsp_valid             = out_v_ff;
   assign rsp_result_kind       = out_k_ff;
   assign rsp_slot              = out_s_ff;
   assign rsp_lowest_sell_price = out_l_ff;
   assign rsp_match_ticker      = out_t_ff;
   assign rsp_match_price       = out_p_ff;
   assign rsp_last              = out_last_ff;

   logic unused_ok;
   assign unused_ok = ^{state_in, any_ff, rd_qty_ff};
endmodule

// ===== rtl/core/hobt_checker.sv =====
// Port-level checker for the hashed order book table, bound to the table module.
module hobt_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_result_kind,
   input logic       rsp_last
);
   import hobt_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_kind))
      else $error("stalled result changed");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind != KIND_MATCH |-> rsp_last)
      else $error("status result without last");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken at once");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_result_kind <= KIND_MATCH)
      else $error("bad result kind");
endmodule

bind hashed_order_book_table hobt_checker u_hobt_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_result_kind(rsp_result_kind), .rsp_last(rsp_last)
);

// ===== sim/tb_top.sv =====
// Self-checking testbench for the hashed order book table.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import hobt_pkg::*;

   localparam int DEPTH = 64;
   localparam logic MODE_ADD   = 1'b0;
   localparam logic MODE_MATCH = 1'b1;
   localparam logic SIDE_BUY   = 1'b0;
   localparam logic SIDE_SELL  = 1'b1;

   typedef struct packed {
      logic [2:0]  kind;
      logic [5:0]  slot;
      logic [30:0] low_sell;
      logic [63:0] mticker;
      logic [30:0] mprice;
      logic        last;
   } book_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_mode = 1'b0;
   logic req_side = 1'b0;
   logic [63:0] req_ticker = '0;
   logic signed [31:0] req_quantity = '0;
   logic signed [31:0] req_price = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [2:0]  rsp_result_kind;
   logic [5:0]  rsp_slot;
   logic [30:0] rsp_lowest_sell_price;
   logic [63:0] rsp_match_ticker;
   logic [30:0] rsp_match_price;
   logic        rsp_last;

   hashed_order_book_table DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the order table.
   logic        book_valid [DEPTH];
   logic [63:0] book_ticker [DEPTH];
   logic        book_side [DEPTH];
   logic [30:0] book_qty [DEPTH];
   logic [30:0] book_price [DEPTH];

   book_result_type pending_results[$];
   int error_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // Pack the fields of one result into a record.
   function automatic book_result_type make_result(logic [2:0] k, logic [5:0] s,
                                               logic [30:0] lo, logic [63:0] t,
                                               logic [30:0] p, logic l);
      book_result_type r;
      r.kind = k; r.slot = s; r.low_sell = lo; r.mticker = t;
      r.mprice = p; r.last = l;
      return r;
   endfunction

   // Clear bytes from the first zero on and fold the rest into the hash.
   function automatic logic [63:0] clean_ticker(logic [63:0] t, output logic [31:0] h);
      logic [63:0] c;
      logic [7:0] b;
      c = '0;
      h = FNV_BASIS;
      for (int i = 0; i < 8; i++) begin
         b = t[8*i +: 8];
         if (b == 8'd0) break;
         c[8*i +: 8] = b;
         h = (h ^ {24'd0, b}) * HASH_MULT;
      end
      return c;
   endfunction

   task automatic predict_book(logic mode, logic side, logic [63:0] ticker,
                               logic signed [31:0] qty, logic signed [31:0] price);
      logic [31:0] h;
      logic [63:0] t;
      int idx;
      logic have;
      logic [30:0] low;
      int hits;
      if (mode == MODE_MATCH) begin
         have = 1'b0;
         low = '0;
         hits = 0;
         for (int i = 0; i < DEPTH; i++)
            if (book_valid[i] && book_side[i] == SIDE_SELL && (!have || book_price[i] < low)) begin
               low = book_price[i];
               have = 1'b1;
            end
         if (!have) begin
            pending_results.push_back(make_result(KIND_NO_SELL, '0, '0, '0, '0, 1'b1));
            return;
         end
         for (int i = 0; i < DEPTH; i++)
            if (book_valid[i] && book_side[i] == SIDE_BUY && book_price[i] >= low) begin
               pending_results.push_back(make_result(KIND_MATCH, 6'(i), low, book_ticker[i],
                                                     book_price[i], 1'b0));
               hits++;
            end
         if (hits == 0)
            pending_results.push_back(make_result(KIND_NO_BUY, '0, low, '0, '0, 1'b1));
         else
            pending_results[$].last = 1'b1;
         return;
      end
      if (qty <= 0 || price <= 0) begin
         pending_results.push_back(make_result(KIND_INVALID, '0, '0, '0, '0, 1'b1));
         return;
      end
      t = clean_ticker(ticker, h);
      idx = int'(h % DEPTH);
      for (int n = 0; n < DEPTH; n++) begin
         if (!book_valid[idx] || book_ticker[idx] == t) begin
            pending_results.push_back(make_result(book_valid[idx] ? KIND_UPDATED : KIND_NEW,
                                                  6'(idx), '0, '0, '0, 1'b1));
            book_valid[idx] = 1'b1;
            book_ticker[idx] = t;
            book_side[idx] = side;
            book_qty[idx] = qty[30:0];
            book_price[idx] = price[30:0];
            return;
         end
         idx = (idx + 1) % DEPTH;
      end
      pending_results.push_back(make_result(KIND_FULL, '0, '0, '0, '0, 1'b1));
   endtask

   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   // Drive one item, hold it until accepted, then predict.
   task automatic send_order(logic mode, logic side, logic [63:0] ticker,
                             logic signed [31:0] qty, logic signed [31:0] price);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_side <= side;
      req_ticker <= ticker;
      req_quantity <= qty;
      req_price <= price;
      do @(posedge clock); while (req_stall);
      predict_book(mode, side, ticker, qty, price);
   endtask

   // Receiver side: random stall, compare each accepted result.
   always @(posedge clock) begin
      book_result_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = make_result(rsp_result_kind, rsp_slot, rsp_lowest_sell_price,
                           rsp_match_ticker, rsp_match_price, rsp_last);
         if (pending_results.size() == 0)
            report_mismatch("result with nothing expected");
         else begin
            want = pending_results.pop_front();
            if (got.kind != want.kind)
               report_mismatch($sformatf("kind %0d want %0d", got.kind, want.kind));
            if (got.slot != want.slot)
               report_mismatch($sformatf("slot %0d want %0d", got.slot, want.slot));
            if (got.low_sell != want.low_sell)
               report_mismatch($sformatf("lowest sell %0d want %0d",
                                         got.low_sell, want.low_sell));
            if (got.mticker != want.mticker)
               report_mismatch($sformatf("ticker %h want %h", got.mticker, want.mticker));
            if (got.mprice != want.mprice)
               report_mismatch($sformatf("price %0d want %0d", got.mprice, want.mprice));
            if (got.last != want.last)
               report_mismatch($sformatf("last %0b want %0b", got.last, want.last));
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   function automatic logic [63:0] rand_ticker();
      logic [63:0] t;
      int len;
      t = {$urandom, $urandom};
      case ($urandom_range(3))
         0: return t;
         default: begin
            // short tickers from a small alphabet so that updates recur
            len = $urandom_range(1, 3);
            t = '0;
            for (int i = 0; i < len; i++) t[8*i +: 8] = 8'h41 + 8'($urandom_range(3));
            return t;
         end
      endcase
   endfunction

   function automatic logic signed [31:0] rand_value();
      case ($urandom_range(9))
         0: return $urandom;
         1: return -$signed(32'($urandom_range(2)));
         default: return $signed(32'($urandom_range(1, 1000)));
      endcase
   endfunction

   task automatic wait_drained();
      int guard;
      req_valid <= 1'b0;
      guard = 0;
      while (pending_results.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (300) @(posedge clock);
   endtask

   task automatic test_directed();
      send_order(MODE_MATCH, SIDE_BUY, '0, 0, 0);                // empty book: no sells
      send_order(MODE_ADD, SIDE_BUY, 64'h4142, 0, 5);            // zero quantity
      send_order(MODE_ADD, SIDE_BUY, 64'h4142, 5, -1);           // negative price
      send_order(MODE_ADD, SIDE_BUY, 64'h4142, 32'h8000_0000, 32'h8000_0000);
      send_order(MODE_ADD, SIDE_BUY, 64'h4142, 32'h7fff_ffff, 10);
      send_order(MODE_MATCH, SIDE_SELL, '1, -1, -1);             // buys only: no sells
      send_order(MODE_ADD, SIDE_SELL, 64'h0000_0000_0000_0000, 3, 20); // empty ticker
      send_order(MODE_MATCH, SIDE_BUY, '0, 0, 0);                // no buy at or above
      send_order(MODE_ADD, SIDE_BUY, 64'hff00_0000_0000_4142, 1, 32'h7fff_ffff); // update
      send_order(MODE_ADD, SIDE_BUY, 64'hffff_ffff_ffff_ffff, 2, 20);
      send_order(MODE_ADD, SIDE_BUY, 64'h8081_8283_8485_8687, 2, 19);
      send_order(MODE_ADD, SIDE_SELL, 64'h4142, 7, 1);           // update flips side
      send_order(MODE_MATCH, SIDE_BUY, '0, 0, 0);
      wait_drained();
   endtask

   task automatic test_fill_table();
      // 70 distinct tickers overflow the 64 slots and probe around the wrap
      for (int i = 0; i < 70; i++)
         send_order(MODE_ADD, 1'($urandom_range(1)), 64'h5a00_0000 | 64'(i + 1),
                    $signed(32'($urandom_range(1, 50))), $signed(32'($urandom_range(1, 50))));
      send_order(MODE_MATCH, SIDE_BUY, '0, 0, 0);
      send_order(MODE_ADD, SIDE_BUY, 64'h5a00_0001, 4, 99);      // update in a full table
      send_order(MODE_MATCH, SIDE_BUY, '0, 0, 0);
      wait_drained();
   endtask

   task automatic test_random(int count, int s_idle, int r_idle);
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      for (int i = 0; i < count; i++)
         if ($urandom_range(5) == 0)
            send_order(MODE_MATCH, 1'($urandom_range(1)), {$urandom, $urandom},
                       $urandom, $urandom);
         else
            send_order(MODE_ADD, 1'($urandom_range(1)), rand_ticker(),
                       rand_value(), rand_value());
      wait_drained();
   endtask

   initial begin
      for (int i = 0; i < DEPTH; i++) begin
         book_valid[i] = 1'b0; book_ticker[i] = '0; book_side[i] = 1'b0;
         book_qty[i] = '0; book_price[i] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 26;
      recv_idle_pct = 46;
      test_directed();
      test_fill_table();
      test_random(60, 26, 46);
      test_random(60, 46, 26);
      test_random(60, 0, 0);
      if (error_count == 0 && pending_results.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("simulation failed");
      $finish;
   end
endmodule
